// ----- design/sto_pkg.sv -----
// shared types and constants of the sorted timeout queue
// no dependencies
`default_nettype none
package sto_pkg;

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_CANCEL   = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam int unsigned MAX_FIRE     = 16;
  localparam int unsigned REG_TICK_STEP = 0;

  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  handler;
    logic [15:0] owner;
    logic [15:0] user;
  } entry_t;

endpackage
`default_nettype wire

// ----- design/sto_mem.sv -----
// entry store of the sorted timeout queue, one write and one registered read port
// depends on sto_pkg
`default_nettype none
module sto_mem
  import sto_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/sorted_timeout_queue.sv -----
// sorted timeout queue: control sequencer, time counter and config register
// depends on sto_pkg and sto_mem
//
// Requests come in on a valid/ready channel, one transfer per item; results leave
// on a valid/ready channel through an output register. Each result carries last=1
// on the final result of its request; a tick gives one result per fired entry, at
// most 16, or one quiet result. The entries sit in one memory in deadline order.
// A register forms the deadline in S_MUL and S_ADD, then walks the list from its
// tail in S_INS_RD and S_INS_EV, moving each later entry up one place, places the
// new entry and hands over the result in S_FIN. Cancel, query and tick make one
// compaction pass over all entries in S_CMP_RD and S_CMP_EV, then close the pass
// and hand over the result in S_FIN. A full list sends a register straight from
// the transfer to S_FIN. The next request is taken once the last result of the
// current one is in the output register.
// If the receiver stalls, the sequencer waits at the next result it must hand
// over, with the memory read data held. Reset empties the list, clears the time
// counter and sets the tick step to 1; the memory itself needs no clearing.
// The tick step register is written over the APB port at byte address 0.
`default_nettype none
module sorted_timeout_queue
  import sto_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  handler_id_i,
  input  wire logic [15:0] owner_ctx_i,
  input  wire logic [15:0] user_ctx_i,
  input  wire logic        owner_any_i,
  input  wire logic        user_any_i,
  input  wire logic [31:0] delay_sec_i,
  input  wire logic [31:0] delay_usec_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [4:0]       count_o,
  output logic             fired_o,
  output logic [7:0]       fired_handler_o,
  output logic [15:0]      fired_owner_ctx_o,
  output logic [15:0]      fired_user_ctx_o,
  output logic             last_o
);

  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned AW = $clog2(TIMER_SLOTS);
  localparam logic [CW-1:0] SLOTS = CW'(TIMER_SLOTS);
  localparam logic [CW-1:0] SAT   = (TIMER_SLOTS > 31) ? CW'(31) : SLOTS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_INS_RD, S_INS_EV, S_CMP_RD, S_CMP_EV, S_FIN
  } state_e;

  state_e        state_q;
  logic [19:0]   step_q;
  logic [63:0]   now_q;
  logic [CW-1:0] count_q;
  logic [1:0]    mode_q;
  logic [7:0]    h_q;
  logic [15:0]   o_q, u_q;
  logic          oany_q, uany_q;
  logic [31:0]   dsec_q, dusec_q;
  logic [51:0]   prod_q;
  logic [63:0]   base_q, dl_q;
  logic [CW-1:0] ptr_q, ri_q, wi_q;
  logic          full_q, found_q, stop_q, pend_q;
  logic [4:0]    fcnt_q, rcnt_q;
  entry_t        pend_e_q;
  logic          out_valid_q;

  entry_t        rdata, wdata, new_e;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic          exact, match, fire, drop, stall, can_emit, emit;
  logic [CW-1:0] removed;

  assign new_e    = '{deadline: dl_q, handler: h_q, owner: o_q, user: u_q};
  assign exact    = (rdata.handler == h_q) && (rdata.owner == o_q) && (rdata.user == u_q);
  assign match    = (rdata.handler == h_q) && (oany_q || rdata.owner == o_q)
                    && (uany_q || rdata.user == u_q);
  assign fire     = !stop_q && (fcnt_q < 5'(MAX_FIRE)) && (rdata.deadline <= now_q);
  assign drop     = (mode_q == MODE_CANCEL) ? match : (mode_q == MODE_TICK) ? fire : 1'b0;
  assign can_emit = !out_valid_q || out_ready_i;
  assign stall    = (mode_q == MODE_TICK) && fire && pend_q && !can_emit;
  assign emit     = ((state_q == S_FIN) && can_emit) ||
                    ((state_q == S_CMP_EV) && (mode_q == MODE_TICK) && fire && pend_q
                     && can_emit);
  assign removed  = count_q - wi_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == 1'(REG_TICK_STEP)) ? {12'b0, step_q} : 32'b0;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = new_e;
    case (state_q)
      S_INS_RD: begin
        if (ptr_q == '0) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = AW'(ptr_q - CW'(1));
        end
      end
      S_INS_EV: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
        if (dl_q < rdata.deadline) begin
          wdata = rdata;
        end
      end
      S_CMP_RD: begin
        if (ri_q != count_q) begin
          re    = 1'b1;
          raddr = ri_q[AW-1:0];
        end
      end
      S_CMP_EV: begin
        if (!drop && !stall) begin
          we    = 1'b1;
          waddr = wi_q[AW-1:0];
          wdata = rdata;
        end
      end
      default: ;
    endcase
  end

  sto_mem #(.DEPTH(TIMER_SLOTS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      step_q            <= 20'd1;
      now_q             <= '0;
      count_q           <= '0;
      out_valid_q       <= 1'b0;
      pend_q            <= 1'b0;
      stop_q            <= 1'b0;
      fcnt_q            <= '0;
      status_o          <= 1'b0;
      count_o           <= '0;
      fired_o           <= 1'b0;
      fired_handler_o   <= '0;
      fired_owner_ctx_o <= '0;
      fired_user_ctx_o  <= '0;
      last_o            <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'(REG_TICK_STEP)) begin
        step_q <= pwdata[19:0];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            h_q     <= handler_id_i;
            o_q     <= owner_ctx_i;
            u_q     <= user_ctx_i;
            oany_q  <= owner_any_i;
            uany_q  <= user_any_i;
            dsec_q  <= delay_sec_i;
            dusec_q <= delay_usec_i;
            ri_q    <= '0;
            wi_q    <= '0;
            found_q <= 1'b0;
            full_q  <= 1'b0;
            pend_q  <= 1'b0;
            stop_q  <= 1'b0;
            fcnt_q  <= '0;
            case (mode_i)
              MODE_REGISTER: begin
                if (count_q >= SLOTS) begin
                  full_q  <= 1'b1;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_MUL;
                end
              end
              MODE_TICK: begin
                now_q   <= now_q + {44'b0, step_q};
                state_q <= S_CMP_RD;
              end
              default: state_q <= S_CMP_RD;
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= dsec_q * USEC_PER_SEC;
          base_q  <= now_q + {32'b0, dusec_q};
          state_q <= S_ADD;
        end
        S_ADD: begin
          dl_q    <= base_q + {12'b0, prod_q};
          ptr_q   <= count_q;
          state_q <= S_INS_RD;
        end
        S_INS_RD: begin
          if (ptr_q == '0) begin
            count_q <= count_q + CW'(1);
            state_q <= S_FIN;
          end else begin
            state_q <= S_INS_EV;
          end
        end
        S_INS_EV: begin
          if (dl_q < rdata.deadline) begin
            ptr_q   <= ptr_q - CW'(1);
            state_q <= S_INS_RD;
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= S_FIN;
          end
        end
        S_CMP_RD: begin
          if (ri_q == count_q) begin
            rcnt_q  <= (removed > SAT) ? 5'(SAT) : 5'(removed);
            count_q <= wi_q;
            state_q <= S_FIN;
          end else begin
            state_q <= S_CMP_EV;
          end
        end
        S_CMP_EV: begin
          if (!stall) begin
            if (mode_q == MODE_QUERY && exact) begin
              found_q <= 1'b1;
            end
            if (!drop) begin
              wi_q <= wi_q + CW'(1);
            end
            ri_q <= ri_q + CW'(1);
            if (mode_q == MODE_TICK) begin
              if (fire) begin
                if (pend_q) begin
                  status_o          <= 1'b0;
                  count_o           <= '0;
                  fired_o           <= 1'b1;
                  fired_handler_o   <= pend_e_q.handler;
                  fired_owner_ctx_o <= pend_e_q.owner;
                  fired_user_ctx_o  <= pend_e_q.user;
                  last_o            <= 1'b0;
                end
                pend_q   <= 1'b1;
                pend_e_q <= rdata;
                fcnt_q   <= fcnt_q + 5'd1;
              end else begin
                stop_q <= 1'b1;
              end
            end
            state_q <= S_CMP_RD;
          end
        end
        S_FIN: begin
          if (can_emit) begin
            status_o          <= (mode_q == MODE_REGISTER) && full_q;
            count_o           <= (mode_q == MODE_CANCEL) ? rcnt_q :
                                 (mode_q == MODE_QUERY) ? {4'b0, found_q} : 5'b0;
            fired_o           <= (mode_q == MODE_TICK) && pend_q;
            fired_handler_o   <= ((mode_q == MODE_TICK) && pend_q) ? pend_e_q.handler : '0;
            fired_owner_ctx_o <= ((mode_q == MODE_TICK) && pend_q) ? pend_e_q.owner : '0;
            fired_user_ctx_o  <= ((mode_q == MODE_TICK) && pend_q) ? pend_e_q.user : '0;
            last_o            <= 1'b1;
            pend_q            <= 1'b0;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= SLOTS)
    else $error("entry count above pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (mode_q == MODE_TICK && state_q != S_IDLE))
    else $error("pending fired entry outside a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP_EV || state_q == S_CMP_RD) |-> (wi_q <= ri_q && ri_q <= count_q))
    else $error("compaction pointers out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni) fcnt_q <= 5'(MAX_FIRE))
    else $error("too many entries fired in one tick");

endmodule
`default_nettype wire

// ----- dv/tb_sorted_timeout_queue.sv -----
// testbench for the sorted timeout queue: scoreboard class, apb and stream drivers
// depends on sto_pkg and the sorted_timeout_queue rtl
`default_nettype none
module tb_sorted_timeout_queue;
  import sto_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic [4:0]  count;
    logic        fired;
    logic [7:0]  handler;
    logic [15:0] owner;
    logic [15:0] user;
    logic        last;
  } outcome_t;

  class timeout_scoreboard;
    logic [63:0] deadline[$];
    logic [7:0]  handler[$];
    logic [15:0] owner[$];
    logic [15:0] user[$];
    logic [63:0] now_usec;
    logic [19:0] step_usec;
    outcome_t    pending[$];
    int          errors;
    int          fired_total;
    int          refused_total;

    function void clear();
      deadline.delete(); handler.delete(); owner.delete(); user.delete();
      pending.delete();
      now_usec = '0;
      step_usec = 20'd1;
      errors = 0;
      fired_total = 0;
      refused_total = 0;
    endfunction

    function int depth();
      return deadline.size();
    endfunction

    function void note_request(logic [1:0] mode, logic [7:0] h, logic [15:0] o,
                               logic [15:0] u, logic oa, logic ua,
                               logic [31:0] ds, logic [31:0] du);
      outcome_t r;
      logic [63:0] dl;
      int pos;
      int removed;
      int n;
      r = '0;
      r.last = 1'b1;
      case (mode)
        MODE_REGISTER: begin
          if (deadline.size() >= 16) begin
            r.status = 1'b1;
            refused_total++;
          end else begin
            dl = now_usec + 64'(ds) * 64'(USEC_PER_SEC) + 64'(du);
            pos = deadline.size();
            for (int i = 0; i < deadline.size(); i++)
              if (dl < deadline[i]) begin
                pos = i;
                break;
              end
            deadline.insert(pos, dl);
            handler.insert(pos, h);
            owner.insert(pos, o);
            user.insert(pos, u);
          end
          pending.push_back(r);
        end
        MODE_CANCEL: begin
          removed = 0;
          for (int i = deadline.size() - 1; i >= 0; i--)
            if (handler[i] == h && (oa || owner[i] == o) && (ua || user[i] == u)) begin
              deadline.delete(i); handler.delete(i); owner.delete(i); user.delete(i);
              removed++;
            end
          r.count = 5'(removed > 31 ? 31 : removed);
          pending.push_back(r);
        end
        MODE_QUERY: begin
          for (int i = 0; i < deadline.size(); i++)
            if (handler[i] == h && owner[i] == o && user[i] == u) begin
              r.count = 5'd1;
              break;
            end
          pending.push_back(r);
        end
        default: begin
          now_usec = now_usec + 64'(step_usec);
          n = 0;
          while (n < MAX_FIRE && deadline.size() > 0 && deadline[0] <= now_usec) begin
            r = '0;
            r.fired = 1'b1;
            r.handler = handler[0];
            r.owner = owner[0];
            r.user = user[0];
            void'(deadline.pop_front()); void'(handler.pop_front());
            void'(owner.pop_front()); void'(user.pop_front());
            pending.push_back(r);
            n++;
          end
          fired_total += n;
          if (n == 0) begin
            r = '0;
            pending.push_back(r);
          end
          pending[$].last = 1'b1;
        end
      endcase
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.count !== want.count) report("count", want.count, got.count);
      if (got.fired !== want.fired) report("fired", want.fired, got.fired);
      if (got.handler !== want.handler) report("fired_handler", want.handler, got.handler);
      if (got.owner !== want.owner) report("fired_owner_ctx", want.owner, got.owner);
      if (got.user !== want.user) report("fired_user_ctx", want.user, got.user);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
      errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [7:0] handler_id_i = '0;
  logic [15:0] owner_ctx_i = '0, user_ctx_i = '0;
  logic owner_any_i = 1'b0, user_any_i = 1'b0;
  logic [31:0] delay_sec_i = '0, delay_usec_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o, fired_o, last_o;
  logic [4:0] count_o;
  logic [7:0] fired_handler_o;
  logic [15:0] fired_owner_ctx_o, fired_user_ctx_o;

  sorted_timeout_queue dut (.*);

  always #5 clk_i = ~clk_i;

  timeout_scoreboard board = new();
  int unsigned cycles = 0;
  int hold_cycles = 0;
  int sent = 0;
  localparam int unsigned CYCLE_LIMIT = 600000;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result({status_o, count_o, fired_o, fired_handler_o,
                          fired_owner_ctx_o, fired_user_ctx_o, last_o});

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (cycles % 400 < 150) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_step(logic [19:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_TICK_STEP * 4); pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.step_usec = value;
  endtask

  task automatic send(logic [1:0] mode, logic [7:0] h, logic [15:0] o, logic [15:0] u,
                      logic oa, logic ua, logic [31:0] ds, logic [31:0] du);
    in_valid_i <= 1'b1;
    mode_i <= mode; handler_id_i <= h; owner_ctx_i <= o; user_ctx_i <= u;
    owner_any_i <= oa; user_any_i <= ua; delay_sec_i <= ds; delay_usec_i <= du;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(mode, h, o, u, oa, ua, ds, du);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic go_idle(int gap);
    in_valid_i <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic random_item();
    int pick;
    logic [7:0] h;
    logic [15:0] o, u;
    pick = $urandom_range(0, 99);
    h = 8'($urandom_range(0, 3));
    o = 16'($urandom_range(0, 2));
    u = 16'($urandom_range(0, 2));
    if (pick < 8) begin
      h = 8'($urandom); o = 16'($urandom); u = 16'($urandom);
    end
    if (pick < 45)
      send(MODE_REGISTER, h, o, u, 1'($urandom), 1'($urandom),
           ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 1)),
           ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3000)));
    else if (pick < 60)
      send(MODE_CANCEL, h, o, u, 1'($urandom), 1'($urandom), $urandom, $urandom);
    else if (pick < 72)
      send(MODE_QUERY, h, o, u, 1'($urandom), 1'($urandom), $urandom, $urandom);
    else
      send(MODE_TICK, h, o, u, 1'($urandom), 1'($urandom), $urandom, $urandom);
  endtask

  initial begin
    logic [19:0] steps [4];
    board.clear();
    steps = '{20'd1000, 20'd0, 20'd1000000, 20'd250000};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_step(20'd1);

    // directed: extremes, full pool, equal deadlines, wildcards, quiet tick
    send(MODE_TICK, 8'h00, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0);
    for (int i = 0; i < 17; i++)
      send(MODE_REGISTER, 8'(i % 3 == 0 ? 8'hff : i), 16'(i % 2 ? 16'hffff : 16'h0),
           16'(i), 1'b0, 1'b0, '0, 32'(i < 8 ? 5 : 3));
    send(MODE_QUERY, 8'hff, 16'h0, 16'h0, 1'b1, 1'b1, '1, '1);
    send(MODE_QUERY, 8'hff, 16'h0, 16'h1, 1'b0, 1'b0, '0, '0);
    send(MODE_CANCEL, 8'hff, 16'h0, 16'h0, 1'b1, 1'b1, '0, '0);
    send(MODE_CANCEL, 8'd1, 16'hffff, 16'h5, 1'b0, 1'b1, '0, '0);
    send(MODE_REGISTER, 8'h7, 16'h7, 16'h7, 1'b0, 1'b0, '1, '1);
    send(MODE_TICK, 8'h0, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0);
    drain();
    write_step(20'hfffff);
    send(MODE_TICK, 8'h0, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_step(steps[phase]);
      while (sent < 25 + (phase + 1) * 60) begin
        repeat ($urandom_range(1, 8)) random_item();
        if ($urandom_range(0, 3) == 0) go_idle($urandom_range(1, 12));
      end
      if (phase == 1) begin
        hold_cycles = 500;
        repeat (40) random_item();
      end
      drain();
    end
    $display("%0d requests sent, %0d entries fired, %0d registers refused",
             sent, board.fired_total, board.refused_total);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
